[rtl/dtp_pkg.sv]
package dtp_pkg;

	localparam int MAX_LEN_BYTES_DEF = 4;
	localparam int FIFO_DEPTH_DEF    = 2;

	localparam int CFG_W   = 32;
	localparam int TDATA_W = 56;

	localparam logic [2:0]  MAX_LEN_BYTES_RST = 3'd4;
	localparam logic [31:0] MAX_OBJ_LEN_RST   = 32'hFFFF_FFFF;

	localparam logic [7:0]  LEN_INDEFINITE = 8'h80;
	localparam logic [31:0] ACC_SHIFT_MAX  = 32'h00FF_FFFF;

	typedef enum logic [0:0] {
		CFG_MAX_LEN_BYTES = 1'b0,
		CFG_MAX_OBJ_LEN   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_NO_LENGTH  = 3'd1,
		ERR_SHORT_LEN  = 3'd2,
		ERR_SHORT_VAL  = 3'd3,
		ERR_INDEFINITE = 3'd4,
		ERR_LEN_WIDE   = 3'd5,
		ERR_TOO_LONG   = 3'd6
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tag;
		logic [31:0] vlen;
		logic [2:0]  lbytes;
		logic [7:0]  vbyte;
		logic        last;
		err_t        err;
	} result_t;

endpackage

[rtl/dtp_front.sv]
module dtp_front import dtp_pkg::*; #(
	parameter int MAX_LEN_BYTES = MAX_LEN_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             push,
	output result_t          push_res
);

	typedef enum logic [1:0] {
		PH_TAG,
		PH_LEN,
		PH_LONG,
		PH_VALUE
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  tag_q, tag_n;
	logic [31:0] acc_q, acc_n;
	logic [2:0]  left_q, left_n;
	logic [2:0]  total_q, total_n;
	logic [31:0] vleft_q, vleft_n;
	logic        skip_q, skip_n;
	logic [2:0]  max_len_q;
	logic [31:0] max_obj_q;

	logic        accept;
	logic        do_fail;
	err_t        fail_code;
	logic        do_finish;
	logic [6:0]  n_len;
	result_t     res;
	logic        has_res;

	assign accept = in_valid && in_ready;
	assign n_len  = in_byte[6:0];

	always_comb begin
		phase_n   = phase_q;
		tag_n     = tag_q;
		acc_n     = acc_q;
		left_n    = left_q;
		total_n   = total_q;
		vleft_n   = vleft_q;
		skip_n    = skip_q;
		do_fail   = 1'b0;
		fail_code = ERR_NONE;
		do_finish = 1'b0;
		has_res   = 1'b0;
		res       = '0;
		if (accept) begin
			if (skip_q) begin
				if (in_last) begin
					skip_n  = 1'b0;
					phase_n = PH_TAG;
				end
			end else begin
				unique case (phase_q)
					PH_TAG: begin
						tag_n = in_byte;
						if (in_last) begin
							do_fail   = 1'b1;
							fail_code = ERR_NO_LENGTH;
						end else begin
							phase_n = PH_LEN;
						end
					end
					PH_LEN: begin
						if (in_byte == LEN_INDEFINITE) begin
							do_fail   = 1'b1;
							fail_code = ERR_INDEFINITE;
						end else if (in_byte[7]) begin
							if (n_len > {4'b0, max_len_q} || n_len > 7'(MAX_LEN_BYTES)) begin
								do_fail   = 1'b1;
								fail_code = ERR_LEN_WIDE;
							end else if (in_last) begin
								do_fail   = 1'b1;
								fail_code = ERR_SHORT_LEN;
							end else begin
								acc_n   = '0;
								left_n  = n_len[2:0];
								total_n = n_len[2:0];
								phase_n = PH_LONG;
							end
						end else begin
							acc_n     = {24'b0, in_byte};
							total_n   = '0;
							left_n    = '0;
							do_finish = 1'b1;
						end
					end
					PH_LONG: begin
						if (acc_q > ACC_SHIFT_MAX) begin
							do_fail   = 1'b1;
							fail_code = ERR_TOO_LONG;
						end else begin
							acc_n  = {acc_q[23:0], in_byte};
							left_n = left_q - 3'd1;
							if (left_n == 3'd0) begin
								do_finish = 1'b1;
							end else if (in_last) begin
								do_fail   = 1'b1;
								fail_code = ERR_SHORT_LEN;
							end
						end
					end
					PH_VALUE: begin
						if (vleft_q <= 32'd1) begin
							vleft_n    = '0;
							has_res    = 1'b1;
							res.kind   = KIND_VALUE;
							res.vlen   = acc_q;
							res.lbytes = total_q;
							res.vbyte  = in_byte;
							res.last   = 1'b1;
							phase_n    = PH_TAG;
						end else if (in_last) begin
							do_fail   = 1'b1;
							fail_code = ERR_SHORT_VAL;
						end else begin
							vleft_n    = vleft_q - 32'd1;
							has_res    = 1'b1;
							res.kind   = KIND_VALUE;
							res.vlen   = acc_q;
							res.lbytes = total_q;
							res.vbyte  = in_byte;
						end
					end
					default: ;
				endcase
				if (do_finish) begin
					if (acc_n > max_obj_q) begin
						do_fail   = 1'b1;
						fail_code = ERR_TOO_LONG;
					end else if (acc_n == 32'd0) begin
						has_res    = 1'b1;
						res.kind   = KIND_HEADER;
						res.lbytes = total_n;
						res.last   = 1'b1;
						phase_n    = PH_TAG;
					end else if (in_last) begin
						do_fail   = 1'b1;
						fail_code = ERR_SHORT_VAL;
					end else begin
						has_res    = 1'b1;
						res.kind   = KIND_HEADER;
						res.vlen   = acc_n;
						res.lbytes = total_n;
						vleft_n    = acc_n;
						phase_n    = PH_VALUE;
					end
				end
				if (do_fail) begin
					has_res  = 1'b1;
					res      = '0;
					res.kind = KIND_ERROR;
					res.err  = fail_code;
					phase_n  = PH_TAG;
					skip_n   = !in_last;
				end
			end
		end
		res.tag = tag_n;
	end

	assign push     = has_res;
	assign push_res = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG;
			tag_q     <= '0;
			acc_q     <= '0;
			left_q    <= '0;
			total_q   <= '0;
			vleft_q   <= '0;
			skip_q    <= 1'b0;
			max_len_q <= MAX_LEN_BYTES_RST;
			max_obj_q <= MAX_OBJ_LEN_RST;
		end else begin
			phase_q <= phase_n;
			tag_q   <= tag_n;
			acc_q   <= acc_n;
			left_q  <= left_n;
			total_q <= total_n;
			vleft_q <= vleft_n;
			skip_q  <= skip_n;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MAX_LEN_BYTES: max_len_q <= cfg_data[2:0];
					CFG_MAX_OBJ_LEN:   max_obj_q <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

endmodule

[rtl/dtp_fifo.sv]
module dtp_fifo import dtp_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    wr_ready,
	input  logic    rd_en,
	output logic    rd_valid,
	output result_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	result_t       mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign wr_ready = count_q != CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/dtp_back.sv]
module dtp_back import dtp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  result_t            q_data,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tlast,
	output logic [1:0]         m_tuser
);

	logic    out_valid_q;
	result_t out_q;

	assign q_pop = q_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= q_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.last;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {2'b0, out_q.err, out_q.vbyte, out_q.lbytes, out_q.vlen, out_q.tag};

endmodule

[rtl/der_tlv_stream_parser.sv]
// A result beat is written to the result queue, then to the output register, before it is offered.
// Throughput: one byte per cycle while the queue has room; each byte needs one pass of the
// front parser FSM. The front stalls only while the two-entry result queue is full: m_tready
// low long enough to fill it, plus the cycle in which m_tready returns high.
// Reset (arst_n low, async): parser expects a tag, queue and output empty, registers
// return to max_length_bytes = 4 and max_object_length = 0xFFFFFFFF.
module der_tlv_stream_parser import dtp_pkg::*; #(
	parameter int MAX_LEN_BYTES = MAX_LEN_BYTES_DEF,
	parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte
	input  logic               s_tlast,   // end_of_buffer
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // tag_byte, value_length, length_bytes, value_byte, error_code
	output logic               m_tlast,   // last_of_object
	output logic [1:0]         m_tuser    // result_kind
);

	logic    push;
	result_t push_res;
	logic    q_valid;
	result_t q_data;
	logic    q_pop;

	dtp_front #(
		.MAX_LEN_BYTES(MAX_LEN_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.push_res (push_res)
	);

	dtp_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_res),
		.wr_ready(s_tready),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_data (q_data)
	);

	dtp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

[rtl/dtp_checker.sv]
module dtp_checker import dtp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic               m_tlast,
	input logic [1:0]         m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed while stalled");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result beat offered during reset");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ERROR |-> !m_tlast && m_tdata[50:8] == '0
			&& m_tdata[53:51] != ERR_NONE)
		else $error("error beat carries header or value fields");

	a_empty_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_HEADER && m_tlast |-> m_tdata[39:8] == '0)
		else $error("last header beat with non-zero length");

	a_value_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_VALUE || m_tuser == KIND_HEADER)
			|-> m_tdata[53:51] == ERR_NONE)
		else $error("non-error beat carries an error code");

endmodule

bind der_tlv_stream_parser dtp_checker u_dtp_checker (.*);

[bench/tb_der_tlv_stream_parser.sv]
`timescale 1ns / 100ps

module tb_der_tlv_stream_parser;
	import dtp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_BYTES = 280;
	localparam int N_PHASES    = 7;

	class tlv_result_tracker;
		typedef enum logic [1:0] {AT_TAG, AT_LEN, AT_LONG, AT_VALUE} parse_t;

		logic [2:0]  max_lbytes = MAX_LEN_BYTES_RST;
		logic [31:0] max_vlen   = MAX_OBJ_LEN_RST;
		parse_t      at         = AT_TAG;
		logic [7:0]  tag        = 8'h00;
		logic [31:0] acc        = '0;
		logic [2:0]  lb_left    = '0;
		logic [2:0]  lb_total   = '0;
		logic [31:0] v_left     = '0;
		logic        skip       = 1'b0;
		result_t     due_results[$];
		int          errors     = 0;

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(cfg_idx_t idx, logic [31:0] v);
			if (idx == CFG_MAX_LEN_BYTES)
				max_lbytes = v[2:0];
			else
				max_vlen = v;
		endfunction

		function void push(kind_t k, logic [31:0] vl, logic [2:0] lb, logic [7:0] vb,
				logic last, err_t e);
			result_t r;
			r.kind   = k;
			r.tag    = tag;
			r.vlen   = vl;
			r.lbytes = lb;
			r.vbyte  = vb;
			r.last   = last;
			r.err    = e;
			due_results.push_back(r);
		endfunction

		// error beat, then drop bytes up to the end of the buffer
		function void flag(err_t e, logic eob);
			push(KIND_ERROR, '0, '0, '0, 1'b0, e);
			at   = AT_TAG;
			skip = !eob;
		endfunction

		function void close_length(logic eob);
			if (acc > max_vlen)
				flag(ERR_TOO_LONG, eob);
			else if (acc == 0) begin
				push(KIND_HEADER, '0, lb_total, '0, 1'b1, ERR_NONE);
				at = AT_TAG;
			end else if (eob)
				flag(ERR_SHORT_VAL, eob);
			else begin
				push(KIND_HEADER, acc, lb_total, '0, 1'b0, ERR_NONE);
				v_left = acc;
				at     = AT_VALUE;
			end
		endfunction

		function void take_byte(logic [7:0] b, logic eob);
			logic [6:0] n;
			n = b[6:0];
			if (skip) begin
				if (eob) begin
					skip = 1'b0;
					at   = AT_TAG;
				end
				return;
			end
			case (at)
				AT_TAG: begin
					tag = b;
					if (eob)
						flag(ERR_NO_LENGTH, eob);
					else
						at = AT_LEN;
				end
				AT_LEN: begin
					if (b == LEN_INDEFINITE)
						flag(ERR_INDEFINITE, eob);
					else if (b[7]) begin
						if (n > max_lbytes || n > MAX_LEN_BYTES_DEF)
							flag(ERR_LEN_WIDE, eob);
						else if (eob)
							flag(ERR_SHORT_LEN, eob);
						else begin
							acc      = '0;
							lb_left  = n[2:0];
							lb_total = n[2:0];
							at       = AT_LONG;
						end
					end else begin
						acc      = {24'd0, b};
						lb_total = '0;
						lb_left  = '0;
						close_length(eob);
					end
				end
				AT_LONG: begin
					if (acc > ACC_SHIFT_MAX)
						flag(ERR_TOO_LONG, eob);
					else begin
						acc     = {acc[23:0], b};
						lb_left = lb_left - 3'd1;
						if (lb_left == 0)
							close_length(eob);
						else if (eob)
							flag(ERR_SHORT_LEN, eob);
					end
				end
				default: begin
					if (v_left <= 1) begin
						v_left = '0;
						push(KIND_VALUE, acc, lb_total, b, 1'b1, ERR_NONE);
						at = AT_TAG;
					end else if (eob)
						flag(ERR_SHORT_VAL, eob);
					else begin
						v_left = v_left - 1;
						push(KIND_VALUE, acc, lb_total, b, 1'b0, ERR_NONE);
					end
				end
			endcase
		endfunction

		task compare(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s: got %0h, want %0h", name, got, want));
		endtask

		// tdata: tag[7:0] vlen[39:8] lbytes[42:40] vbyte[50:43] err[53:51]
		task match_result(logic [TDATA_W-1:0] d, logic last, logic [1:0] kind);
			result_t w;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected beat tuser=%0d tdata=%h", kind, d));
				return;
			end
			w = due_results.pop_front();
			compare("result_kind", 32'(kind), 32'(w.kind));
			compare("tag_byte", 32'(d[7:0]), 32'(w.tag));
			compare("value_length", d[39:8], w.vlen);
			compare("length_bytes", 32'(d[42:40]), 32'(w.lbytes));
			compare("value_byte", 32'(d[50:43]), 32'(w.vbyte));
			compare("last_of_object", 32'(last), 32'(w.last));
			compare("error_code", 32'(d[53:51]), 32'(w.err));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	cfg_idx_t           cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // data_byte
	logic               s_tlast;   // end_of_buffer
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // tag_byte, value_length, length_bytes, value_byte, error_code
	logic               m_tlast;   // last_of_object
	logic [1:0]         m_tuser;   // result_kind

	tlv_result_tracker tracker = new;
	bit                calm = 1'b0;
	int                sent;
	int                quiet = 0;
	logic [7:0]        buf_q[$];

	der_tlv_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 37);
		if (arst_n) begin
			if (m_tvalid && m_tready)
				tracker.match_result(m_tdata, m_tlast, m_tuser);
			if (s_tvalid && s_tready)
				tracker.take_byte(s_tdata, s_tlast);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet <= 0;
			else if (quiet >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else
				quiet <= quiet + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eob);
		while (!calm && $urandom_range(0, 99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	// leaves cfg_we high; the caller drops it after its last write
	task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		tracker.set_reg(idx, v);
	endtask

	task automatic settle();
		@(posedge clk);
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void add_tlv();
		int unsigned len, r, n, need;
		r = $urandom_range(0, 99);
		len = r < 70 ? $urandom_range(0, 6) :
			r < 92 ? $urandom_range(7, 40) :
			r < 97 ? $urandom_range(100, 140) : $urandom_range(250, 300);
		need = len < 256 ? 1 : 2;
		buf_q.push_back(8'($urandom));
		if (len < 128 && $urandom_range(0, 1) == 1)
			buf_q.push_back(len[7:0]);
		else begin
			n = $urandom_range(need, 4);
			if ($urandom_range(0, 19) == 0)
				n = $urandom_range(0, 7);
			buf_q.push_back(8'h80 | n[7:0]);
			for (int i = int'(n) - 1; i >= 0; i--)
				buf_q.push_back(8'(len >> (8 * i)));
		end
		repeat (len) buf_q.push_back(8'($urandom));
	endfunction

	task automatic send_buffer();
		int r, cut;
		buf_q.delete();
		repeat ($urandom_range(1, 3)) add_tlv();
		r = $urandom_range(0, 99);
		if (r >= 94) begin
			buf_q.delete();
			repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom));
		end else if (r >= 88) begin
			// huge declared length, cut short
			buf_q.delete();
			buf_q.push_back(8'($urandom));
			buf_q.push_back(8'h84);
			repeat (4 + $urandom_range(0, 3)) buf_q.push_back(8'($urandom));
		end else if (r >= 75) begin
			cut = $urandom_range(1, buf_q.size());
			while (buf_q.size() > cut)
				void'(buf_q.pop_back());
		end
		foreach (buf_q[i])
			send_byte(buf_q[i], i == buf_q.size() - 1);
	endtask

	task automatic run_directed();
		send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);                          // empty value
		send_byte(8'hFF, 1'b0); send_byte(8'h02, 1'b0);
		send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b1);
		send_byte(8'h30, 1'b1);                                                  // tag only
		send_byte(8'h04, 1'b0); send_byte(8'h81, 1'b1);                          // long form cut
		send_byte(8'h24, 1'b0); send_byte(LEN_INDEFINITE, 1'b0);                 // indefinite
		send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b1);
		send_byte(8'h02, 1'b0); send_byte(8'h85, 1'b1);                          // too many len bytes
		send_byte(8'h04, 1'b0); send_byte(8'h03, 1'b0);                          // value cut
		send_byte(8'hAA, 1'b0); send_byte(8'hBB, 1'b1);
		send_byte(8'h05, 1'b0); send_byte(8'h05, 1'b1);                          // ends on length
		send_byte(8'h30, 1'b0); send_byte(8'h84, 1'b0);                          // max length
		send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b1);
		s_tvalid <= 1'b0;
	endtask

	initial begin
		logic [2:0]  lb_set [N_PHASES];
		logic [31:0] len_set[N_PHASES];
		lb_set  = '{3'd4, 3'd1, 3'd0, 3'd4, 3'd7, 3'd2, 3'd3};
		len_set = '{32'hFFFF_FFFF, 32'd0, 32'd16, 32'hFFFF_FFFF, 32'd300,
			$urandom_range(0, 200), 32'd100};
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_MAX_LEN_BYTES;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		m_tready  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			cfg_write(CFG_MAX_LEN_BYTES, {29'd0, lb_set[p]});
			cfg_write(CFG_MAX_OBJ_LEN, len_set[p]);
			cfg_we <= 1'b0;
			calm = (p == 3);
			if (p == 1) begin
				// any non-zero length is over the limit
				send_byte(8'h13, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h77, 1'b1);
			end
			sent = 0;
			while (sent < PHASE_BYTES)
				send_buffer();
			s_tvalid <= 1'b0;
		end
		calm = 1'b0;
		settle();

		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
rtl/dtp_pkg.sv
rtl/dtp_front.sv
rtl/dtp_fifo.sv
rtl/dtp_back.sv
rtl/der_tlv_stream_parser.sv
rtl/dtp_checker.sv
bench/tb_der_tlv_stream_parser.sv
